>>> src/wedt_pkg.sv
// ---------------------------------------------------------------------------
// wedt_pkg
// shared types, codes and constants of the windowed event dedupe tracker
// ---------------------------------------------------------------------------
`default_nettype none
package wedt_pkg;

    localparam int MAX_EVENTS_DEF = 16;
    localparam logic [31:0] TOTAL_CAP = 32'd1000000;

    typedef enum logic [2:0] {
        CMD_START_HDR = 3'd0,
        CMD_SEED      = 3'd1,
        CMD_START_FIN = 3'd2,
        CMD_END       = 3'd3,
        CMD_SUBMIT    = 3'd4,
        CMD_SNAPSHOT  = 3'd5,
        CMD_RSVD6     = 3'd6,
        CMD_RSVD7     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_DEDUPE = 2'd1,
        REG_SKEW   = 2'd2
    } t_reg_idx;

    // one command as it travels through the queue
    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] tag;
        logic [31:0] ckpt;
        logic [31:0] age;
        logic [47:0] now;
        logic [1:0]  src;
        logic [31:0] cli;
        logic [31:0] num;
        logic [47:0] et;
    } t_item;

    // one result item
    typedef struct packed {
        logic        accepted;
        logic        is_active;
        logic [63:0] active_tag;
        logic [31:0] revision;
        logic [31:0] total_count;
        logic [4:0]  window_count;
        logic [47:0] last_time;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRUNE,
        ST_SCAN,
        ST_SHIFT,
        ST_APPLY,
        ST_LOAD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] rev_bump(input logic [31:0] r);
        logic [31:0] v;
        v = r + 32'd1;
        if (v == 32'd0) v = 32'd1;
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/wedt_front.sv
// ---------------------------------------------------------------------------
// wedt_front
// input side: takes items, drops unused codes, and holds a two-entry queue
// ---------------------------------------------------------------------------
`default_nettype none
module wedt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire wedt_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output wedt_pkg::t_item      o_item
);
    import wedt_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop, w_keep;

    // unused codes cause no result and are simply dropped
    assign w_keep  = (i_item.cmd != CMD_RSVD6) && (i_item.cmd != CMD_RSVD7);
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready && w_keep;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

>>> src/wedt_back.sv
// ---------------------------------------------------------------------------
// wedt_back
// execution side: prunes, scans and updates the stores one entry a cycle
// ---------------------------------------------------------------------------
`default_nettype none
module wedt_back #(
    parameter int MAX_EVENTS = wedt_pkg::MAX_EVENTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire wedt_pkg::t_item i_item,
    input  wire logic [31:0]     i_window_ms,
    input  wire logic [31:0]     i_dedupe_ms,
    input  wire logic [31:0]     i_skew_ms,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output wedt_pkg::t_result    o_result
);
    import wedt_pkg::*;

    localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_EVENTS);

    t_state r_st, n_st;
    t_item  r_it;

    logic [47:0] r_times [MAX_EVENTS];
    logic [1:0]  r_ssrc  [MAX_EVENTS];
    logic [31:0] r_scli  [MAX_EVENTS];
    logic [31:0] r_snum  [MAX_EVENTS];

    logic          r_active;
    logic [63:0]   r_tag;
    logic [31:0]   r_rev, r_total;
    logic [CW-1:0] r_tcnt, r_scnt;
    logic [2:0]    r_flags;
    logic [47:0]   r_snow;

    // scan bookkeeping
    logic [CW-1:0] r_idx, r_kept;
    logic          r_near, r_seen, r_acc;
    logic [47:0]   r_cand;   // time to test / insert
    logic [CW-1:0] r_pos;    // insert position
    logic          r_dropold;
    t_result       r_res;

    logic [IW-1:0] w_i, w_k;
    logic [47:0]   w_t, w_d;
    logic          w_expire;
    logic [48:0]   w_fut;

    assign w_i  = r_idx[IW-1:0];
    assign w_k  = r_kept[IW-1:0];
    assign w_t  = r_times[w_i];
    assign w_d  = (w_t >= r_cand) ? (w_t - r_cand) : (r_cand - w_t);
    assign w_expire = (r_it.now >= w_t) && ((r_it.now - w_t) > {16'd0, i_window_ms});
    assign w_fut = {1'b0, r_it.now} + {17'd0, i_skew_ms};

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_valid) n_st = ST_PRUNE;
            ST_PRUNE: if (r_idx >= r_tcnt) n_st = ST_SCAN;
            ST_SCAN:  if (r_idx >= r_tcnt && r_idx >= r_scnt) n_st = ST_SHIFT;
            ST_SHIFT: if (r_idx == 0) n_st = ST_APPLY;
            ST_APPLY: n_st = ST_LOAD;
            ST_LOAD:  n_st = ST_OUT;
            ST_OUT:   if (i_ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready  = (r_st == ST_IDLE);
        o_valid  = (r_st == ST_OUT);
        o_result = r_res;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic ok_seed;
        logic [47:0] sd;
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_active <= 1'b0; r_tag <= '0; r_rev <= '0;
            r_total <= '0; r_tcnt <= '0; r_scnt <= '0; r_flags <= '0; r_snow <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    r_it <= i_item; r_idx <= '0; r_kept <= '0;
                end
                ST_PRUNE: begin
                    if (r_idx < r_tcnt) begin
                        if (!w_expire) begin
                            r_times[w_k] <= w_t;
                            r_kept <= r_kept + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        if (r_active && r_kept != r_tcnt) r_rev <= rev_bump(r_rev);
                        r_tcnt <= r_kept;
                        r_idx <= '0; r_near <= 1'b0; r_seen <= 1'b0;
                        sd = (r_snow >= {16'd0, r_it.age}) ? r_snow - {16'd0, r_it.age} : '0;
                        r_cand <= (r_it.cmd == CMD_SEED) ? sd : r_it.et;
                    end
                end
                ST_SCAN: begin
                    if (r_idx < r_tcnt && w_d <= {16'd0, i_dedupe_ms}) r_near <= 1'b1;
                    if (r_idx < r_scnt && r_ssrc[w_i] == r_it.src &&
                        r_scli[w_i] == r_it.cli && r_snum[w_i] == r_it.num) r_seen <= 1'b1;
                    if (r_idx < r_tcnt || r_idx < r_scnt) r_idx <= r_idx + 1'b1;
                    else begin
                        // decide the insert and set up the shift pass
                        r_acc <= !(!r_active || r_tag != r_it.tag || r_it.cli == 0 ||
                                   r_it.et == 0 || {1'b0, r_it.et} > w_fut ||
                                   (r_it.now >= r_it.et &&
                                    (r_it.now - r_it.et) > {16'd0, i_window_ms}));
                        ok_seed = (r_it.cmd == CMD_SEED) && r_flags[2] &&
                                  (r_it.age <= i_window_ms) && !r_near && (r_tcnt < FULL);
                        r_dropold <= 1'b0;
                        r_idx <= '0;
                        if (ok_seed) begin
                            r_pos <= r_tcnt; r_idx <= r_tcnt;
                        end else if (r_it.cmd == CMD_SUBMIT && !r_near && !r_seen) begin
                            // acceptance checked again in apply; only place when accepted
                            if (r_active && r_tag == r_it.tag && r_it.cli != 0 &&
                                r_it.et != 0 && !({1'b0, r_it.et} > w_fut) &&
                                !(r_it.now >= r_it.et &&
                                  (r_it.now - r_it.et) > {16'd0, i_window_ms})) begin
                                if (r_tcnt >= FULL) begin
                                    r_dropold <= 1'b1; r_idx <= CW'(1);
                                end else begin
                                    r_pos <= r_tcnt; r_idx <= r_tcnt;
                                end
                            end
                        end
                        r_kept <= '0;
                    end
                end
                ST_SHIFT: begin
                    if (r_dropold) begin
                        // first move every time down one slot, then insert from the top
                        if (r_kept < FULL - 1'b1) begin
                            r_times[w_k] <= r_times[IW'(r_kept + 1'b1)];
                            r_kept <= r_kept + 1'b1;
                            r_idx <= CW'(1);
                        end else begin
                            r_dropold <= 1'b0;
                            r_tcnt <= FULL - 1'b1;
                            r_pos <= FULL - 1'b1; r_idx <= FULL - 1'b1;
                        end
                    end else if (r_idx != 0) begin
                        if (r_times[IW'(r_idx - 1'b1)] > r_cand) begin
                            r_times[w_i] <= r_times[IW'(r_idx - 1'b1)];
                            r_idx <= r_idx - 1'b1;
                            r_pos <= r_idx - 1'b1;
                        end else r_idx <= '0;
                    end
                end
                ST_APPLY: begin
                    case (r_it.cmd)
                        CMD_START_HDR: begin
                            if (!r_active || r_tag != r_it.tag) begin
                                r_active <= 1'b1; r_tag <= r_it.tag; r_rev <= 32'd1;
                                r_total <= r_it.ckpt; r_tcnt <= '0; r_scnt <= '0;
                                r_flags <= 3'b101;
                            end else if (r_it.ckpt > r_total) begin
                                r_total <= r_it.ckpt; r_rev <= rev_bump(r_rev);
                                r_flags <= 3'b101;
                            end else r_flags <= 3'b100;
                            r_snow <= r_it.now;
                        end
                        CMD_SEED: begin
                            if (r_flags[2] && r_it.age <= i_window_ms && !r_near &&
                                r_tcnt < FULL) begin
                                r_times[IW'(r_pos)] <= r_cand;
                                r_tcnt <= r_tcnt + 1'b1;
                                r_flags[1] <= 1'b1;
                            end
                        end
                        CMD_START_FIN: begin
                            if (r_flags[2]) begin
                                if ((r_flags[1] && !r_flags[0] ? rev_bump(r_rev) : r_rev) == 0)
                                    r_rev <= 32'd1;
                                else if (r_flags[1] && !r_flags[0]) r_rev <= rev_bump(r_rev);
                                r_flags <= '0;
                            end
                        end
                        CMD_END: begin
                            if (r_active && r_tag == r_it.tag) begin
                                r_active <= 1'b0; r_tag <= '0; r_rev <= '0; r_total <= '0;
                                r_tcnt <= '0; r_scnt <= '0; r_flags <= '0; r_snow <= '0;
                            end
                        end
                        CMD_SUBMIT: begin
                            if (r_acc && !r_seen) begin
                                if (r_scnt >= FULL) begin
                                    for (int j = 1; j < MAX_EVENTS; j++) begin
                                        r_ssrc[j-1] <= r_ssrc[j];
                                        r_scli[j-1] <= r_scli[j];
                                        r_snum[j-1] <= r_snum[j];
                                    end
                                    r_ssrc[MAX_EVENTS-1] <= r_it.src;
                                    r_scli[MAX_EVENTS-1] <= r_it.cli;
                                    r_snum[MAX_EVENTS-1] <= r_it.num;
                                end else begin
                                    r_ssrc[IW'(r_scnt)] <= r_it.src;
                                    r_scli[IW'(r_scnt)] <= r_it.cli;
                                    r_snum[IW'(r_scnt)] <= r_it.num;
                                    r_scnt <= r_scnt + 1'b1;
                                end
                                if (!r_near) begin
                                    r_times[IW'(r_pos)] <= r_cand;
                                    r_tcnt <= r_tcnt + 1'b1;
                                    if (r_total < TOTAL_CAP) r_total <= r_total + 32'd1;
                                    r_rev <= rev_bump(r_rev);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_LOAD: ;
                ST_OUT: ;
                default: ;
            endcase
            if (r_st == ST_APPLY) r_idx <= '0;
        end
    end

    // result register: accept flag at apply, snapshot once apply has settled
    always_ff @(posedge i_clk) begin
        if (r_st == ST_APPLY) begin
            r_res.accepted <= (r_it.cmd == CMD_SUBMIT) ? r_acc : 1'b1;
        end
        if (r_st == ST_LOAD) begin
            r_res.is_active    <= r_active;
            r_res.active_tag   <= r_tag;
            r_res.revision     <= r_rev;
            r_res.total_count  <= r_total;
            r_res.window_count <= 5'(r_tcnt);
            r_res.last_time    <= (r_tcnt != 0) ? r_times[IW'(r_tcnt - 1'b1)] : 48'd0;
        end
    end
endmodule
`default_nettype wire

>>> src/windowed_event_dedupe_tracker_unit.sv
// ---------------------------------------------------------------------------
// windowed_event_dedupe_tracker_unit
// session event tracker with window pruning and key/time deduplication
// ---------------------------------------------------------------------------
// Each command runs in order: take the item, prune the N stored times,
// compare against every stored time and each of the K stored keys, place a
// new time by moving each later time up one slot (a full store first drops
// its oldest by moving every time down one slot), then the update, the
// snapshot and the result.
// A two-entry queue holds arriving items while one executes.
`default_nettype none
module windowed_event_dedupe_tracker_unit #(
    parameter int MAX_EVENTS = wedt_pkg::MAX_EVENTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // cmd
    input  wire logic [2:0]   s_axis_tuser,
    // session_tag, start total, seed_age, now_time, source, client,
    // event_number, event_time (total 290 bits, zero-filled to 296)
    input  wire logic [295:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // accepted, is_active, active_tag, revision, total_count, window_count,
    // last_time (total 183 bits, zero-filled to 184)
    output logic [183:0]      m_axis_tdata
);
    import wedt_pkg::*;

    t_item   w_in, w_q;
    t_result w_res;
    logic    w_qv, w_qr;
    logic [31:0] r_win, r_ded, r_skew;

    assign w_in.cmd  = t_cmd'(s_axis_tuser);
    assign w_in.tag  = s_axis_tdata[63:0];
    assign w_in.ckpt = s_axis_tdata[95:64];
    assign w_in.age  = s_axis_tdata[127:96];
    assign w_in.now  = s_axis_tdata[175:128];
    assign w_in.src  = s_axis_tdata[177:176];
    assign w_in.cli  = s_axis_tdata[209:178];
    assign w_in.num  = s_axis_tdata[241:210];
    assign w_in.et   = s_axis_tdata[289:242];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 32'd600000; r_ded <= 32'd2000; r_skew <= 32'd5000;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_WINDOW: r_win  <= i_cfg_data;
                REG_DEDUPE: r_ded  <= i_cfg_data;
                REG_SKEW:   r_skew <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wedt_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    wedt_back #(.MAX_EVENTS(MAX_EVENTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .i_window_ms(r_win), .i_dedupe_ms(r_ded), .i_skew_ms(r_skew),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.last_time, w_res.window_count, w_res.total_count,
                           w_res.revision, w_res.active_tag, w_res.is_active,
                           w_res.accepted};
endmodule
`default_nettype wire

>>> src/wedt_checker.sv
// ---------------------------------------------------------------------------
// wedt_checker
// port-level checks of the tracker
// ---------------------------------------------------------------------------
`default_nettype none
module wedt_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [183:0] m_axis_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // inactive means no tag
    a_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[65:2] == 64'd0)
        else $error("tag without session");
    // window count never exceeds sixteen
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[134:130] <= 5'd16)
        else $error("window count overflow");
endmodule

bind windowed_event_dedupe_tracker_unit wedt_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
